### rtl/smoothed_follow_look_at_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef SMOOTHED_FOLLOW_LOOK_AT_ASSERT_SVH
`define SMOOTHED_FOLLOW_LOOK_AT_ASSERT_SVH

// Same-cycle implication under reset.
`define SFLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under reset.
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sfla_pkg.sv
package sfla_pkg;

    // CORDIC settings
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CNT_W = $clog2(CORDIC_ITERATIONS + 1);
    localparam int VEC_W = 46;
    localparam int ANGLE_W = 28;

    // Fixed-point constants
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [18:0] PI_Q16 = 19'sd205887;
    localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Register indexes
    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z = 3'd2;
    localparam logic [2:0] REG_LOOK_X = 3'd3;
    localparam logic [2:0] REG_LOOK_Y = 3'd4;
    localparam logic [2:0] REG_LOOK_Z = 3'd5;
    localparam logic [2:0] REG_RATE = 3'd6;

    // Request to the CORDIC unit
    typedef struct packed {
        logic start;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] x;
    } cordic_req_t;

    // Response from the CORDIC unit
    typedef struct packed {
        logic done;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [VEC_W-1:0] mag;
    } cordic_rsp_t;

    // Arctangent of 2^-i in Q4.24
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [ANGLE_W-1:0] v;
        begin
            case (i)
                5'd0: v = 28'sd13176795;
                5'd1: v = 28'sd7778716;
                5'd2: v = 28'sd4110060;
                5'd3: v = 28'sd2086331;
                5'd4: v = 28'sd1047214;
                5'd5: v = 28'sd524117;
                5'd6: v = 28'sd262123;
                5'd7: v = 28'sd131069;
                5'd8: v = 28'sd65536;
                5'd9: v = 28'sd32768;
                5'd10: v = 28'sd16384;
                5'd11: v = 28'sd8192;
                5'd12: v = 28'sd4096;
                5'd13: v = 28'sd2048;
                5'd14: v = 28'sd1024;
                5'd15: v = 28'sd512;
                5'd16: v = 28'sd256;
                5'd17: v = 28'sd128;
                5'd18: v = 28'sd64;
                5'd19: v = 28'sd32;
                5'd20: v = 28'sd16;
                5'd21: v = 28'sd8;
                5'd22: v = 28'sd4;
                5'd23: v = 28'sd2;
                5'd24: v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

### rtl/sfla_cordic.sv
module sfla_cordic
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfla_pkg::cordic_req_t req,
    output sfla_pkg::cordic_rsp_t rsp
);

    logic signed [sfla_pkg::VEC_W-1:0] x_reg, x_next;
    logic signed [sfla_pkg::VEC_W-1:0] y_reg, y_next;
    logic signed [sfla_pkg::ANGLE_W-1:0] z_reg, z_next;
    logic [sfla_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic signed [sfla_pkg::VEC_W-1:0] xs, ys;
    logic signed [sfla_pkg::ANGLE_W-1:0] at;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = sfla_pkg::atan_entry(5'(cnt_reg));

    // Prerotate on start (a zero vector returns zeros), then one micro-rotation per cycle
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next = '0;
            if (req.x == '0 && req.y == '0)
            begin
                x_next = '0;
                y_next = '0;
                z_next = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                if (req.x < 0)
                begin
                    if (req.y >= 0)
                    begin
                        x_next = req.y;
                        y_next = -req.x;
                        z_next = sfla_pkg::HALF_PI_Q24;
                    end
                    else
                    begin
                        x_next = -req.y;
                        y_next = req.x;
                        z_next = -sfla_pkg::HALF_PI_Q24;
                    end
                end
                else
                begin
                    x_next = req.x;
                    y_next = req.y;
                    z_next = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            cnt_next = cnt_reg + sfla_pkg::CNT_W'(1);
            if (cnt_reg == sfla_pkg::CNT_W'(sfla_pkg::CORDIC_ITERATIONS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done = done_reg;
    assign rsp.angle = z_reg;
    assign rsp.mag = x_reg;

endmodule

### rtl/smoothed_follow_look_at.sv
// Channel   Signals                                    Transfer when
// input     action target_x/y/z time_step in_valid     in_valid && !in_stall
// output    follower_x/y/z pitch yaw angles_valid      out_valid && !out_stall
// config    cfg_we cfg_index cfg_data                  cfg_we
//
// A step item computes the gain and the three axis moves on a shared 47x25
// multiplier, then the look vector, then two CORDIC passes, scaling the
// first pass's magnitude on the same multiplier and restarting the unit
// between them, and last loads the output register. A step that lands too
// close skips the CORDIC passes; a place item goes straight to the output load.
// Reset clears the follower position, the registers to their defaults and
// the sequencer. A new item is taken once the sequencer is idle, even while
// a result waits under out_stall; a finished result waits for the output
// register to free up.
`include "smoothed_follow_look_at_assert.svh"

module smoothed_follow_look_at
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic [23:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] follower_x,
    output logic signed [31:0] follower_y,
    output logic signed [31:0] follower_z,
    output logic signed [17:0] pitch,
    output logic signed [18:0] yaw,
    output logic               angles_valid
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_K    = 4'd1;
    localparam logic [3:0] S_KS   = 4'd2;
    localparam logic [3:0] S_MX   = 4'd3;
    localparam logic [3:0] S_UX   = 4'd4;
    localparam logic [3:0] S_MY   = 4'd5;
    localparam logic [3:0] S_UY   = 4'd6;
    localparam logic [3:0] S_MZ   = 4'd7;
    localparam logic [3:0] S_UZ   = 4'd8;
    localparam logic [3:0] S_LOOK = 4'd9;
    localparam logic [3:0] S_C1   = 4'd10;
    localparam logic [3:0] S_H    = 4'd11;
    localparam logic [3:0] S_C2S  = 4'd12;
    localparam logic [3:0] S_C2   = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    localparam int VW = sfla_pkg::VEC_W;

    logic [3:0] state_reg, state_next;

    logic signed [31:0] off_x_reg, off_y_reg, off_z_reg;
    logic signed [31:0] look_x_reg, look_y_reg, look_z_reg;
    logic [23:0] rate_reg;

    logic signed [31:0] held_x_reg, held_y_reg, held_z_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic [23:0] dt_reg;
    logic [16:0] k_reg;
    logic signed [71:0] prod_reg;
    logic signed [33:0] dy_reg;
    logic signed [VW-1:0] mag_reg;
    logic signed [18:0] yaw_reg;
    logic signed [17:0] pitch_reg;
    logic valid_reg;

    logic out_valid_reg;
    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic signed [17:0] pitch_out_reg;
    logic signed [18:0] yaw_out_reg;
    logic valid_out_reg;

    logic in_xfer, out_free;
    logic signed [46:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [71:0] mul_p;
    logic signed [33:0] diff;
    logic signed [31:0] held_cur;
    logic signed [35:0] move_sum;
    logic signed [31:0] move_sat;
    logic [31:0] kp;
    logic signed [33:0] dx, dy, dz;
    logic near, too_close;
    logic signed [3:0] dxs, dys, dzs;
    logic signed [7:0] sqx, sqy, sqz;
    logic [8:0] sq_sum;
    logic signed [28:0] ang_round;
    logic signed [20:0] ang_q16;
    logic signed [18:0] yaw_clamp;
    logic signed [17:0] pitch_neg;
    sfla_pkg::cordic_req_t creq;
    sfla_pkg::cordic_rsp_t crsp;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Select the axis under update
    always_comb
    begin
        case (state_reg)
            S_MX, S_UX: diff = 34'(tx_reg) + 34'(off_x_reg) - 34'(held_x_reg);
            S_MY, S_UY: diff = 34'(ty_reg) + 34'(off_y_reg) - 34'(held_y_reg);
            default:    diff = 34'(tz_reg) + 34'(off_z_reg) - 34'(held_z_reg);
        endcase
        case (state_reg)
            S_UX:    held_cur = held_x_reg;
            S_UY:    held_cur = held_y_reg;
            default: held_cur = held_z_reg;
        endcase
    end

    // Shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_K:
            begin
                mul_a = $signed({23'd0, dt_reg});
                mul_b = $signed({1'b0, rate_reg});
            end
            S_H:
            begin
                mul_a = 47'(mag_reg);
                mul_b = $signed({9'd0, sfla_pkg::INV_GAIN_Q16});
            end
            default:
            begin
                mul_a = 47'(diff);
                mul_b = $signed({8'd0, k_reg});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Gain and saturated move
    assign kp = prod_reg[47:16];
    assign move_sum = 36'(held_cur) + prod_reg[51:16];
    always_comb
    begin
        if (move_sum > 36'sd2147483647)
            move_sat = 32'sh7FFFFFFF;
        else if (move_sum < -36'sd2147483648)
            move_sat = 32'sh80000000;
        else
            move_sat = move_sum[31:0];
    end

    // Look vector and the near-zero check
    assign dx = 34'(tx_reg) + 34'(look_x_reg) - 34'(held_x_reg);
    assign dy = 34'(ty_reg) + 34'(look_y_reg) - 34'(held_y_reg);
    assign dz = 34'(tz_reg) + 34'(look_z_reg) - 34'(held_z_reg);
    assign near = (dx > -34'sd7) && (dx < 34'sd7) && (dy > -34'sd7) && (dy < 34'sd7)
                  && (dz > -34'sd7) && (dz < 34'sd7);
    assign dxs = dx[3:0];
    assign dys = dy[3:0];
    assign dzs = dz[3:0];
    assign sqx = dxs * dxs;
    assign sqy = dys * dys;
    assign sqz = dzs * dzs;
    assign sq_sum = 9'(sqx[6:0]) + 9'(sqy[6:0]) + 9'(sqz[6:0]);
    assign too_close = near && (sq_sum < 9'd43);

    // Round the CORDIC angle to Q3.16 and clamp
    assign ang_round = 29'(crsp.angle) + 29'sd128;
    assign ang_q16 = 21'(ang_round >>> 8);
    always_comb
    begin
        if (ang_q16 > 21'(sfla_pkg::PI_Q16))
            yaw_clamp = sfla_pkg::PI_Q16;
        else if (ang_q16 < -21'(sfla_pkg::PI_Q16))
            yaw_clamp = -sfla_pkg::PI_Q16;
        else
            yaw_clamp = ang_q16[18:0];
        if (ang_q16 > 21'(sfla_pkg::HALF_PI_Q16))
            pitch_neg = -18'(sfla_pkg::HALF_PI_Q16);
        else if (ang_q16 < -21'(sfla_pkg::HALF_PI_Q16))
            pitch_neg = 18'(sfla_pkg::HALF_PI_Q16);
        else
            pitch_neg = -ang_q16[17:0];
    end

    // CORDIC requests
    always_comb
    begin
        creq.start = 1'b0;
        creq.y = VW'(dx) <<< 8;
        creq.x = VW'(dz) <<< 8;
        if (state_reg == S_LOOK)
            creq.start = !too_close;
        else if (state_reg == S_C2S)
        begin
            creq.start = 1'b1;
            creq.y = VW'(dy_reg) <<< 8;
            creq.x = prod_reg[VW+15:16];
        end
    end

    sfla_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_xfer) state_next = action ? S_FIN : S_K;
            S_K:    state_next = S_KS;
            S_KS:   state_next = S_MX;
            S_MX:   state_next = S_UX;
            S_UX:   state_next = S_MY;
            S_MY:   state_next = S_UY;
            S_UY:   state_next = S_MZ;
            S_MZ:   state_next = S_UZ;
            S_UZ:   state_next = S_LOOK;
            S_LOOK: state_next = too_close ? S_FIN : S_C1;
            S_C1:   if (crsp.done) state_next = S_H;
            S_H:    state_next = S_C2S;
            S_C2S:  state_next = S_C2;
            S_C2:   if (crsp.done) state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control, configuration and follower state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            off_x_reg <= 32'sd0;
            off_y_reg <= 32'sd393216;
            off_z_reg <= -32'sd786432;
            look_x_reg <= 32'sd0;
            look_y_reg <= 32'sd65536;
            look_z_reg <= 32'sd0;
            rate_reg <= 24'd262144;
            held_x_reg <= '0;
            held_y_reg <= '0;
            held_z_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sfla_pkg::REG_OFFSET_X: off_x_reg <= cfg_data;
                    sfla_pkg::REG_OFFSET_Y: off_y_reg <= cfg_data;
                    sfla_pkg::REG_OFFSET_Z: off_z_reg <= cfg_data;
                    sfla_pkg::REG_LOOK_X:   look_x_reg <= cfg_data;
                    sfla_pkg::REG_LOOK_Y:   look_y_reg <= cfg_data;
                    sfla_pkg::REG_LOOK_Z:   look_z_reg <= cfg_data;
                    sfla_pkg::REG_RATE:     rate_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (in_xfer && action)
            begin
                held_x_reg <= target_x;
                held_y_reg <= target_y;
                held_z_reg <= target_z;
            end
            case (state_reg)
                S_UX: held_x_reg <= move_sat;
                S_UY: held_y_reg <= move_sat;
                S_UZ: held_z_reg <= move_sat;
                default: ;
            endcase
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (in_xfer)
        begin
            tx_reg <= target_x;
            ty_reg <= target_y;
            tz_reg <= target_z;
            dt_reg <= time_step;
            yaw_reg <= '0;
            pitch_reg <= '0;
            valid_reg <= 1'b0;
        end
        if (state_reg == S_KS)
        begin
            if (rate_reg == '0 || kp > 32'(sfla_pkg::ONE_Q16))
                k_reg <= sfla_pkg::ONE_Q16;
            else
                k_reg <= kp[16:0];
        end
        if (state_reg == S_LOOK)
        begin
            dy_reg <= dy;
            valid_reg <= !too_close;
        end
        if (state_reg == S_C1 && crsp.done)
        begin
            yaw_reg <= yaw_clamp;
            mag_reg <= crsp.mag;
        end
        if (state_reg == S_C2 && crsp.done)
            pitch_reg <= pitch_neg;
        if (state_reg == S_FIN && out_free)
        begin
            fx_reg <= held_x_reg;
            fy_reg <= held_y_reg;
            fz_reg <= held_z_reg;
            pitch_out_reg <= pitch_reg;
            yaw_out_reg <= yaw_reg;
            valid_out_reg <= valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign follower_x = fx_reg;
    assign follower_y = fy_reg;
    assign follower_z = fz_reg;
    assign pitch = pitch_out_reg;
    assign yaw = yaw_out_reg;
    assign angles_valid = valid_out_reg;

    `SFLA_ASSERT_IMP(a_cordic_done_expected, clk, rst_n, crsp.done,
        state_reg == S_C1 || state_reg == S_C2)
    `SFLA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_xfer, in_stall)
    `SFLA_ASSERT_IMP(a_gain_capped, clk, rst_n, state_reg == S_MX,
        k_reg <= sfla_pkg::ONE_Q16)

endmodule
